// ===== sv/tgr_pkg.sv =====
// Shared types, widths and constants of the triangle grid rasterizer.
package tgr_pkg;

    localparam int MAX_SPAN = 8;
    localparam int GRID_MAX = 4096;

    localparam int CW  = 32;                      // coordinate / depth width
    localparam int DW  = CW + 1;                  // vertex difference width
    localparam int LW  = CW + 2;                  // cell number width
    localparam int QW  = CW + 3;                  // corner offset width
    localparam int MW  = QW + 1;                  // multiplier operand width
    localparam int WW  = 2 * MW;                  // weight width
    localparam int SW  = WW + DW + 1;             // weighted depth sum width
    localparam int QDW = CW + 2;                  // depth quotient bits
    localparam int SPW = $clog2(MAX_SPAN + 1);    // span count width
    localparam int GW  = $clog2(GRID_MAX) + 1;    // grid size width
    localparam int PW  = 31;                      // pitch width
    localparam int IW  = 24;                      // cell index width

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic [PW-1:0]        pitch;
        logic [GW-1:0]        cols;
        logic [GW-1:0]        rows;
    } cfg_t;

    // One classified triangle, handed from the front to the back
    typedef struct packed {
        logic                 ovf;
        logic signed [LW-1:0] lx;
        logic signed [LW-1:0] ly;
        logic [SPW-1:0]       nx;
        logic [SPW-1:0]       ny;
        logic signed [WW-1:0] area;
        logic signed [WW-1:0] wa0;
        logic signed [WW-1:0] wb0;
        logic signed [WW-1:0] dax;
        logic signed [WW-1:0] day;
        logic signed [WW-1:0] dbx;
        logic signed [WW-1:0] dby;
        logic signed [DW-1:0] dza;
        logic signed [DW-1:0] dzb;
        logic signed [CW-1:0] cz;
    } desc_t;

endpackage

// ===== sv/tgr_front.sv =====
// Front end: takes a triangle, computes area, cell box and scan setup.
module tgr_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tgr_pkg::cfg_t         cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_first_x,
    input  logic signed [31:0]    s_first_y,
    input  logic signed [31:0]    s_first_z,
    input  logic signed [31:0]    s_second_x,
    input  logic signed [31:0]    s_second_y,
    input  logic signed [31:0]    s_second_z,
    input  logic signed [31:0]    s_third_x,
    input  logic signed [31:0]    s_third_y,
    input  logic signed [31:0]    s_third_z,
    output logic                  push_valid,
    input  logic                  push_ready,
    output tgr_pkg::desc_t        push_desc
);

    typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_FIN, F_PUSH} state_t;

    localparam int CW = tgr_pkg::CW;
    localparam int DW = tgr_pkg::DW;
    localparam int LW = tgr_pkg::LW;
    localparam int QW = tgr_pkg::QW;
    localparam int MW = tgr_pkg::MW;
    localparam int WW = tgr_pkg::WW;
    localparam int PW = tgr_pkg::PW;
    localparam int NL = 4;          // lanes: low x, high x, low y, high y

    function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [3:0] k_reg;

    logic signed [CW-1:0] ax_reg, ay_reg, az_reg;
    logic signed [CW-1:0] bx_reg, by_reg, bz_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;

    logic [DW-1:0]   dvd_reg [NL];
    logic [PW-1:0]   rem_reg [NL];
    logic            neg_reg [NL];

    logic signed [DW-1:0] num_in   [NL];
    logic [DW-1:0]        dvd_init [NL];
    logic [DW-1:0]        dvd_step [NL];
    logic [PW-1:0]        rem_step [NL];
    logic signed [LW-1:0] q_lane   [NL];
    logic [PW-1:0]        fr_lane  [NL];

    logic signed [WW-1:0] prod_reg, prod;
    logic signed [WW-1:0] area_reg, wa_reg, wb_reg, dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [3:0]           sel;

    logic signed [DW-1:0] ea, eb, ec, ed, fy;
    logic signed [QW-1:0] qx0, qy0;
    logic signed [LW:0]   spx, spy;
    logic                 flip;
    logic signed [WW-1:0] area_abs;
    tgr_pkg::desc_t       desc_reg, desc_next;

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_desc  = desc_reg;

    // box numerators straight from the incoming vertices
    assign num_in[0] = DW'(min3(s_first_x, s_second_x, s_third_x)) - DW'(cfg.origin_x);
    assign num_in[1] = DW'(max3(s_first_x, s_second_x, s_third_x)) - DW'(cfg.origin_x);
    assign num_in[2] = DW'(min3(s_first_y, s_second_y, s_third_y)) - DW'(cfg.origin_y);
    assign num_in[3] = DW'(max3(s_first_y, s_second_y, s_third_y)) - DW'(cfg.origin_y);

    // floor division lanes, one quotient bit per cycle
    always_comb begin
        logic [DW:0] m_in;
        logic [PW:0] r2;
        logic        ge;
        for (int l = 0; l < NL; l++) begin
            if (num_in[l] < 0) begin
                m_in = (DW+1)'(-(DW+1)'(num_in[l])) + (DW+1)'(cfg.pitch) - (DW+1)'(1);
            end else begin
                m_in = (DW+1)'(num_in[l]);
            end
            dvd_init[l] = m_in[DW-1:0];
            r2 = {rem_reg[l], dvd_reg[l][DW-1]};
            ge = (r2 >= {1'b0, cfg.pitch});
            rem_step[l] = ge ? PW'(r2 - {1'b0, cfg.pitch}) : r2[PW-1:0];
            dvd_step[l] = {dvd_reg[l][DW-2:0], ge};
            q_lane[l]  = neg_reg[l] ? -$signed({1'b0, dvd_reg[l]}) : $signed({1'b0, dvd_reg[l]});
            fr_lane[l] = neg_reg[l] ? (cfg.pitch - PW'(1) - rem_reg[l]) : rem_reg[l];
        end
    end

    assign ea = DW'(by_reg) - DW'(cy_reg);
    assign eb = DW'(cx_reg) - DW'(bx_reg);
    assign ec = DW'(cy_reg) - DW'(ay_reg);
    assign ed = DW'(ax_reg) - DW'(cx_reg);
    assign fy = DW'(ay_reg) - DW'(cy_reg);

    // offset of the low box corner from vertex three
    assign qx0 = QW'(min3(ax_reg, bx_reg, cx_reg)) - QW'(cx_reg) - $signed(QW'(fr_lane[0]));
    assign qy0 = QW'(min3(ay_reg, by_reg, cy_reg)) - QW'(cy_reg) - $signed(QW'(fr_lane[2]));

    always_comb begin
        unique case (k_reg)
            4'd0:    begin mul_a = MW'(ea); mul_b = MW'(ed);  end
            4'd1:    begin mul_a = MW'(eb); mul_b = MW'(fy);  end
            4'd2:    begin mul_a = MW'(ea); mul_b = MW'(qx0); end
            4'd3:    begin mul_a = MW'(eb); mul_b = MW'(qy0); end
            4'd4:    begin mul_a = MW'(ec); mul_b = MW'(qx0); end
            4'd5:    begin mul_a = MW'(ed); mul_b = MW'(qy0); end
            4'd6:    begin mul_a = MW'(ea); mul_b = $signed(MW'(cfg.pitch)); end
            4'd7:    begin mul_a = MW'(eb); mul_b = $signed(MW'(cfg.pitch)); end
            4'd8:    begin mul_a = MW'(ec); mul_b = $signed(MW'(cfg.pitch)); end
            4'd9:    begin mul_a = MW'(ed); mul_b = $signed(MW'(cfg.pitch)); end
            default: begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign sel  = k_reg - 4'd1;

    assign spx      = (LW+1)'(q_lane[1]) - (LW+1)'(q_lane[0]);
    assign spy      = (LW+1)'(q_lane[3]) - (LW+1)'(q_lane[2]);
    assign flip     = area_reg[WW-1];
    assign area_abs = flip ? -area_reg : area_reg;

    always_comb begin
        desc_next.ovf  = (spx > (LW+1)'(tgr_pkg::MAX_SPAN)) ||
                         (spy > (LW+1)'(tgr_pkg::MAX_SPAN));
        desc_next.lx   = q_lane[0];
        desc_next.ly   = q_lane[2];
        desc_next.nx   = spx[tgr_pkg::SPW-1:0];
        desc_next.ny   = spy[tgr_pkg::SPW-1:0];
        desc_next.area = area_abs;
        desc_next.wa0  = flip ? -wa_reg  : wa_reg;
        desc_next.wb0  = flip ? -wb_reg  : wb_reg;
        desc_next.dax  = flip ? -dax_reg : dax_reg;
        desc_next.day  = flip ? -day_reg : day_reg;
        desc_next.dbx  = flip ? -dbx_reg : dbx_reg;
        desc_next.dby  = flip ? -dby_reg : dby_reg;
        desc_next.dza  = DW'(az_reg) - DW'(cz_reg);
        desc_next.dzb  = DW'(bz_reg) - DW'(cz_reg);
        desc_next.cz   = cz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        ax_reg <= s_first_x;  ay_reg <= s_first_y;  az_reg <= s_first_z;
                        bx_reg <= s_second_x; by_reg <= s_second_y; bz_reg <= s_second_z;
                        cx_reg <= s_third_x;  cy_reg <= s_third_y;  cz_reg <= s_third_z;
                        for (int l = 0; l < NL; l++) begin
                            dvd_reg[l] <= dvd_init[l];
                            rem_reg[l] <= '0;
                            neg_reg[l] <= (num_in[l] < 0);
                        end
                        cnt_reg   <= '0;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    for (int l = 0; l < NL; l++) begin
                        dvd_reg[l] <= dvd_step[l];
                        rem_reg[l] <= rem_step[l];
                    end
                    if (cnt_reg == 6'(DW - 1)) begin
                        k_reg     <= '0;
                        state_reg <= F_MUL;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                F_MUL: begin
                    prod_reg <= prod;
                    if (k_reg != 4'd0) begin
                        unique case (sel)
                            4'd0:    area_reg <= prod_reg;
                            4'd1:    area_reg <= area_reg + prod_reg;
                            4'd2:    wa_reg   <= prod_reg;
                            4'd3:    wa_reg   <= wa_reg + prod_reg;
                            4'd4:    wb_reg   <= prod_reg;
                            4'd5:    wb_reg   <= wb_reg + prod_reg;
                            4'd6:    dax_reg  <= prod_reg;
                            4'd7:    day_reg  <= prod_reg;
                            4'd8:    dbx_reg  <= prod_reg;
                            4'd9:    dby_reg  <= prod_reg;
                            default: ;
                        endcase
                    end
                    if (k_reg == 4'd10) begin
                        state_reg <= F_FIN;
                    end else begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                F_FIN: begin
                    // degenerate triangle: nothing to hand on
                    if (area_reg == '0) begin
                        state_reg <= F_IDLE;
                    end else begin
                        desc_reg  <= desc_next;
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (push_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/tgr_queue.sv =====
// Two-entry queue of triangle descriptors between front and back.
module tgr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  tgr_pkg::desc_t push_desc,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tgr_pkg::desc_t pop_desc
);

    tgr_pkg::desc_t slot_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                slot_reg[wr_ptr_reg] <= push_desc;
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/tgr_back.sv =====
// Back end: scans the cell box, tests corners, interpolates depth, emits results.
module tgr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  tgr_pkg::cfg_t      cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  tgr_pkg::desc_t     pop_desc,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_cell_index,
    output logic signed [31:0] m_depth,
    output logic               m_last,
    output logic               m_box_overflow
);

    typedef enum logic [2:0] {
        B_IDLE, B_CELL, B_MAC, B_DSET, B_DIV, B_PUT, B_FLUSH, B_OVF
    } state_t;

    localparam int CW  = tgr_pkg::CW;
    localparam int DW  = tgr_pkg::DW;
    localparam int LW  = tgr_pkg::LW;
    localparam int WW  = tgr_pkg::WW;
    localparam int SW  = tgr_pkg::SW;
    localparam int QDW = tgr_pkg::QDW;
    localparam int SPW = tgr_pkg::SPW;
    localparam int GW  = tgr_pkg::GW;
    localparam int IW  = tgr_pkg::IW;
    localparam int RB  = GW - 1;       // bits of an in-grid row or column

    state_t                state_reg;
    tgr_pkg::desc_t        d_reg;
    logic [SPW-1:0]        i_reg, j_reg;
    logic signed [LW-1:0]  col_reg, row_reg;
    logic signed [WW-1:0]  wa_row_reg, wb_row_reg, wa_cur_reg, wb_cur_reg;
    logic signed [SW-1:0]  acc_reg;
    logic [5:0]            k_reg;
    logic [WW-1:0]         drem_reg;
    logic [QDW-1:0]        ddvd_reg;
    logic                  dneg_reg;
    logic [IW-1:0]         idx_reg;
    logic                  pend_valid_reg;
    logic [IW-1:0]         pend_idx_reg;
    logic signed [CW-1:0]  pend_depth_reg;
    logic                  m_valid_reg, m_last_reg, m_ovf_reg;
    logic [IW-1:0]         m_idx_reg;
    logic signed [CW-1:0]  m_depth_reg;

    logic                  out_free, ingrid, hit, last_cell, row_end, do_adv;
    logic signed [WW-1:0]  wc;
    logic [IW:0]           idx_next;
    logic [5:0]            bidx;
    logic signed [SW-1:0]  ta, tb, term, nn;
    logic [SW-1:0]         mm;
    logic [WW-1:0]         dd;
    logic [WW:0]           r2;
    logic                  ge;
    logic [QDW-1:0]        tq;
    logic signed [CW-1:0]  depth_new;
    logic                  push_out, put_ok;
    logic [IW-1:0]         push_idx;
    logic signed [CW-1:0]  push_depth;
    logic                  push_last, push_ovf;

    assign m_valid        = m_valid_reg;
    assign m_cell_index   = m_idx_reg;
    assign m_depth        = m_depth_reg;
    assign m_last         = m_last_reg;
    assign m_box_overflow = m_ovf_reg;

    assign pop_ready = (state_reg == B_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign ingrid = (col_reg >= 0) && (col_reg < $signed(LW'(cfg.cols))) &&
                    (row_reg >= 0) && (row_reg < $signed(LW'(cfg.rows)));
    assign wc     = d_reg.area - wa_cur_reg - wb_cur_reg;
    assign hit    = ingrid && (wa_cur_reg > 0) && (wb_cur_reg > 0) && (wc > 0);
    assign idx_next = (IW+1)'(row_reg[RB-1:0]) * (IW+1)'(cfg.cols) +
                      (IW+1)'(col_reg[RB-1:0]);

    assign row_end   = (j_reg == d_reg.nx - SPW'(1));
    assign last_cell = row_end && (i_reg == d_reg.ny - SPW'(1));

    // shift-add weighted depth sum, multiplier bits from the top
    assign bidx = 6'(DW - 1) - k_reg;
    assign ta   = d_reg.dza[bidx] ? SW'(wa_cur_reg) : '0;
    assign tb   = d_reg.dzb[bidx] ? SW'(wb_cur_reg) : '0;
    assign term = ta + tb;

    // round to nearest: floor((2*sum + area) / (2*area))
    assign dd = {d_reg.area[WW-2:0], 1'b0};
    assign nn = (acc_reg <<< 1) + SW'(d_reg.area);
    assign mm = nn[SW-1] ? (SW'(-nn) + SW'(dd) - SW'(1)) : nn;

    assign r2 = {drem_reg, ddvd_reg[QDW-1]};
    assign ge = (r2 >= {1'b0, dd});

    assign tq        = dneg_reg ? -ddvd_reg : ddvd_reg;
    assign depth_new = d_reg.cz + $signed(tq[CW-1:0]);

    assign put_ok = (state_reg == B_PUT) && (!pend_valid_reg || out_free);
    assign do_adv = ((state_reg == B_CELL) && !hit) || put_ok;

    always_comb begin
        push_out   = 1'b0;
        push_idx   = pend_idx_reg;
        push_depth = pend_depth_reg;
        push_last  = 1'b0;
        push_ovf   = 1'b0;
        unique case (state_reg)
            B_PUT:   push_out = pend_valid_reg && out_free;
            B_FLUSH: begin
                push_out  = pend_valid_reg && out_free;
                push_last = 1'b1;
            end
            B_OVF: begin
                push_out   = out_free;
                push_idx   = '0;
                push_depth = '0;
                push_last  = 1'b1;
                push_ovf   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            k_reg          <= '0;
        end else begin
            if (push_out) begin
                m_valid_reg <= 1'b1;
                m_idx_reg   <= push_idx;
                m_depth_reg <= push_depth;
                m_last_reg  <= push_last;
                m_ovf_reg   <= push_ovf;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (do_adv) begin
                if (row_end) begin
                    j_reg      <= '0;
                    col_reg    <= d_reg.lx;
                    i_reg      <= i_reg + SPW'(1);
                    row_reg    <= row_reg + LW'(1);
                    wa_row_reg <= wa_row_reg + d_reg.day;
                    wb_row_reg <= wb_row_reg + d_reg.dby;
                    wa_cur_reg <= wa_row_reg + d_reg.day;
                    wb_cur_reg <= wb_row_reg + d_reg.dby;
                end else begin
                    j_reg      <= j_reg + SPW'(1);
                    col_reg    <= col_reg + LW'(1);
                    wa_cur_reg <= wa_cur_reg + d_reg.dax;
                    wb_cur_reg <= wb_cur_reg + d_reg.dbx;
                end
            end

            unique case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        d_reg      <= pop_desc;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        col_reg    <= pop_desc.lx;
                        row_reg    <= pop_desc.ly;
                        wa_row_reg <= pop_desc.wa0;
                        wb_row_reg <= pop_desc.wb0;
                        wa_cur_reg <= pop_desc.wa0;
                        wb_cur_reg <= pop_desc.wb0;
                        if (pop_desc.ovf) begin
                            state_reg <= B_OVF;
                        end else if (pop_desc.nx == '0 || pop_desc.ny == '0) begin
                            state_reg <= B_FLUSH;
                        end else begin
                            state_reg <= B_CELL;
                        end
                    end
                end
                B_CELL: begin
                    if (hit) begin
                        idx_reg   <= idx_next[IW-1:0];
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= B_MAC;
                    end else if (last_cell) begin
                        state_reg <= B_FLUSH;
                    end
                end
                B_MAC: begin
                    // top multiplier bit carries negative weight
                    acc_reg <= (acc_reg <<< 1) + ((k_reg == '0) ? -term : term);
                    if (k_reg == 6'(DW - 1)) begin
                        state_reg <= B_DSET;
                    end else begin
                        k_reg <= k_reg + 6'd1;
                    end
                end
                B_DSET: begin
                    dneg_reg  <= nn[SW-1];
                    drem_reg  <= mm[SW-1:QDW];
                    ddvd_reg  <= mm[QDW-1:0];
                    k_reg     <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    drem_reg <= ge ? WW'(r2 - {1'b0, dd}) : r2[WW-1:0];
                    ddvd_reg <= {ddvd_reg[QDW-2:0], ge};
                    if (k_reg == 6'(QDW - 1)) begin
                        state_reg <= B_PUT;
                    end else begin
                        k_reg <= k_reg + 6'd1;
                    end
                end
                B_PUT: begin
                    // hold one hit back so the final one can carry last
                    if (put_ok) begin
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= idx_reg;
                        pend_depth_reg <= depth_new;
                        state_reg      <= last_cell ? B_FLUSH : B_CELL;
                    end
                end
                B_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= B_IDLE;
                    end else if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                B_OVF: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/triangle_grid_rasterizer_core.sv =====
// Top level of the triangle grid rasterizer: config registers, front, queue, back.
// In the front each triangle goes through a 33-step floor divide of the
// bounding box by the cell pitch, then ten products through one shared multiplier.
// The back then scans the box of at most 8 x 8 cells: a cell that is not a hit is
// passed over, and each hit takes a 33-step shift-add for the depth sum and a
// 34-step divide by the doubled area. A two-entry descriptor queue lets the front
// take and set up the next triangles while the back still scans; results leave
// through an output register, and the last result of a triangle is flagged.
module triangle_grid_rasterizer_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_first_x,
    input  logic signed [31:0] s_first_y,
    input  logic signed [31:0] s_first_z,
    input  logic signed [31:0] s_second_x,
    input  logic signed [31:0] s_second_y,
    input  logic signed [31:0] s_second_z,
    input  logic signed [31:0] s_third_x,
    input  logic signed [31:0] s_third_y,
    input  logic signed [31:0] s_third_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_cell_index,
    output logic signed [31:0] m_depth,
    output logic               m_last,
    output logic               m_box_overflow
);

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_CELL_STEP   = 3'd2,
        REG_GRID_WIDTH  = 3'd3,
        REG_GRID_HEIGHT = 3'd4
    } reg_index_t;

    localparam int PW = tgr_pkg::PW;
    localparam int GW = tgr_pkg::GW;

    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [PW-1:0]      cell_step_reg;
    logic [GW-1:0]      grid_width_reg, grid_height_reg;
    tgr_pkg::cfg_t      cfg;

    logic               q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    tgr_pkg::desc_t     q_push_desc, q_pop_desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_step_reg   <= PW'(65536);
            grid_width_reg  <= GW'(tgr_pkg::GRID_MAX);
            grid_height_reg <= GW'(tgr_pkg::GRID_MAX);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                REG_CELL_STEP:   cell_step_reg   <= cfg_data[PW-1:0];
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // zero pitch acts as one, oversize grid clamps
    assign cfg.origin_x = origin_x_reg;
    assign cfg.origin_y = origin_y_reg;
    assign cfg.pitch    = (cell_step_reg == '0) ? PW'(1) : cell_step_reg;
    assign cfg.cols     = (grid_width_reg > GW'(tgr_pkg::GRID_MAX)) ?
                          GW'(tgr_pkg::GRID_MAX) : grid_width_reg;
    assign cfg.rows     = (grid_height_reg > GW'(tgr_pkg::GRID_MAX)) ?
                          GW'(tgr_pkg::GRID_MAX) : grid_height_reg;

    tgr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_first_x  (s_first_x),
        .s_first_y  (s_first_y),
        .s_first_z  (s_first_z),
        .s_second_x (s_second_x),
        .s_second_y (s_second_y),
        .s_second_z (s_second_z),
        .s_third_x  (s_third_x),
        .s_third_y  (s_third_y),
        .s_third_z  (s_third_z),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_desc  (q_push_desc)
    );

    tgr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_desc  (q_push_desc),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_desc   (q_pop_desc)
    );

    tgr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .pop_valid      (q_pop_valid),
        .pop_ready      (q_pop_ready),
        .pop_desc       (q_pop_desc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_index   (m_cell_index),
        .m_depth        (m_depth),
        .m_last         (m_last),
        .m_box_overflow (m_box_overflow)
    );

    a_ovf_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_box_overflow |-> m_last && m_cell_index == '0 && m_depth == '0)
        else $error("overflow result malformed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front took a second triangle during setup");

    a_desc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_desc))
        else $error("descriptor dropped while queue full");

endmodule
